@@ design/assert_macros.svh @@
// Assertion macros for the touch pad controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TPBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ design/tpbd_pkg.sv @@
// Shared types, codes and elaboration helpers for the touch pad baseline/detect block.
package tpbd_pkg;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd100;

    localparam logic MODE_CAL  = 1'b0;
    localparam logic MODE_SCAN = 1'b1;
    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        logic cal_write;
        logic scan_update;
        logic sort_step;
        logic acc_clear;
        logic sum_add;
        logic div_step;
        logic load_out;
        logic out_kind;
    } cmd_t;

    typedef struct packed {
        logic cal_last;
        logic scan_last;
    } status_t;

    // samples dropped from each end; clipped so at least one sample is averaged
    function automatic int trim_eff(int n, int t);
        return (2 * t >= n) ? (n - 1) / 2 : t;
    endfunction

    function automatic int kept_count(int n, int t);
        return n - 2 * trim_eff(n, t);
    endfunction

    function automatic int sum_width(int k);
        return COUNT_W + $clog2(k);
    endfunction

    // step counter covers the sort passes, which are never fewer than the kept samples
    function automatic int step_width(int n);
        return $clog2(n);
    endfunction

endpackage

@@ design/touch_pad_baseline_and_detect_core.sv @@
// Top level of the touch pad baseline and touch detect block.
// Input channel (s_valid/s_ready): s_mode selects calibration (0) or scan (1);
// s_charge_count is the measured pad charge time.
// Result channel (m_valid/m_ready): m_kind 0 = calibration finished, 1 = scan
// decision; m_touched flags a touch; m_baseline_value is the current baseline.
// cfg_wr_en/cfg_wr_data write the touch threshold (reset value 100).
// Calibration: every CAL_SAMPLES-th calibration item triggers an odd-even sort,
// a trimmed sum (one kept sample per cycle) and a reciprocal-multiply divide;
// s_ready stays low until the result is loaded into the output register.
// Other calibration items are only stored and leave s_ready high.
// Scan: the last item of each SCAN_SAMPLES group loads its result into the
// output register through an emit state, with s_ready low until then.
// The result sits in an output register; the block keeps working while it
// waits, and holds off the next result until the previous item is taken.
// Reset clears counters, running maximum and baseline and loads the threshold.
module touch_pad_baseline_and_detect_core #(
    parameter int CAL_SAMPLES   = 10,
    parameter int TRIM_EACH_END = 2,
    parameter int SCAN_SAMPLES  = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_charge_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_touched,
    output logic [15:0] m_baseline_value
);

    localparam int STEP_W = tpbd_pkg::step_width(CAL_SAMPLES);

    tpbd_pkg::cmd_t    cmd;
    tpbd_pkg::status_t status;
    logic [STEP_W-1:0] step;

    tpbd_ctrl #(
        .CAL_SAMPLES   (CAL_SAMPLES),
        .TRIM_EACH_END (TRIM_EACH_END),
        .STEP_W        (STEP_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mode   (s_mode),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .status    (status),
        .cmd       (cmd),
        .step      (step)
    );

    tpbd_datapath #(
        .CAL_SAMPLES   (CAL_SAMPLES),
        .TRIM_EACH_END (TRIM_EACH_END),
        .SCAN_SAMPLES  (SCAN_SAMPLES),
        .STEP_W        (STEP_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_count     (s_charge_count),
        .cmd          (cmd),
        .step         (step),
        .status       (status),
        .out_kind     (m_kind),
        .out_touched  (m_touched),
        .out_baseline (m_baseline_value)
    );

endmodule

@@ design/tpbd_datapath.sv @@
// Datapath: sample store with odd-even sort, trimmed sum, reciprocal divide, scan tracking.
module tpbd_datapath #(
    parameter int CAL_SAMPLES   = 10,
    parameter int TRIM_EACH_END = 2,
    parameter int SCAN_SAMPLES  = 3,
    parameter int STEP_W        = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tpbd_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic [tpbd_pkg::COUNT_W-1:0]  in_count,
    input  tpbd_pkg::cmd_t                cmd,
    input  logic [STEP_W-1:0]             step,
    output tpbd_pkg::status_t             status,
    output logic                          out_kind,
    output logic                          out_touched,
    output logic [tpbd_pkg::COUNT_W-1:0]  out_baseline
);

    localparam int CW     = tpbd_pkg::COUNT_W;
    localparam int TRIM   = tpbd_pkg::trim_eff(CAL_SAMPLES, TRIM_EACH_END);
    localparam int KEPT   = tpbd_pkg::kept_count(CAL_SAMPLES, TRIM_EACH_END);
    localparam int SUM_W  = tpbd_pkg::sum_width(KEPT);
    localparam int CIDX_W = $clog2(CAL_SAMPLES);
    localparam int SCNT_W = $clog2(SCAN_SAMPLES + 1);
    // sum / KEPT == (sum * RECIP) >> DIV_S, exact for every SUM_W-bit sum
    localparam int DIV_S  = SUM_W + $clog2(KEPT);
    localparam int PROD_W = 2 * SUM_W + 2;
    localparam logic [SUM_W+1:0] RECIP =
        (SUM_W+2)'(((64'd1 << DIV_S) + 64'(KEPT - 1)) / 64'(KEPT));

    logic [CW-1:0]     cal_mem [CAL_SAMPLES];
    logic [CW-1:0]     sorted_next [CAL_SAMPLES];
    logic [CIDX_W-1:0] cal_count_reg;
    logic [SCNT_W-1:0] scan_count_reg;
    logic [CW-1:0]     scan_max_reg;
    logic [CW-1:0]     baseline_reg;
    logic [CW-1:0]     threshold_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [CIDX_W-1:0] sum_idx;
    logic [PROD_W-1:0] product;
    logic [CW-1:0]     quotient;
    logic              hit;

    assign status.cal_last  = (cal_count_reg == CIDX_W'(CAL_SAMPLES - 1));
    assign status.scan_last = (scan_count_reg == SCNT_W'(SCAN_SAMPLES - 1));

    // one odd-even transposition pass; step[0] picks the pair phase
    always_comb begin
        sorted_next = cal_mem;
        for (int i = 0; i < CAL_SAMPLES - 1; i++) begin
            if ((i[0] == step[0]) && (cal_mem[i] > cal_mem[i+1])) begin
                sorted_next[i]   = cal_mem[i+1];
                sorted_next[i+1] = cal_mem[i];
            end
        end
    end

    assign sum_idx  = CIDX_W'(TRIM) + step[CIDX_W-1:0];
    assign product  = PROD_W'(acc_reg) * PROD_W'(RECIP);
    assign quotient = product[DIV_S +: CW];
    assign hit      = ({1'b0, scan_max_reg} > ({1'b0, baseline_reg} + {1'b0, threshold_reg}));

    always_ff @(posedge aclk) begin
        if (cmd.cal_write) begin
            cal_mem[cal_count_reg] <= in_count;
        end else if (cmd.sort_step) begin
            cal_mem <= sorted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg  <= '0;
            scan_count_reg <= '0;
            scan_max_reg   <= '0;
            baseline_reg   <= '0;
            threshold_reg  <= tpbd_pkg::THRESHOLD_RESET;
        end else begin
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            if (cmd.cal_write) begin
                cal_count_reg <= status.cal_last ? '0 : cal_count_reg + 1'b1;
            end
            if (cmd.scan_update) begin
                if (in_count > scan_max_reg) begin
                    scan_max_reg <= in_count;
                end
                scan_count_reg <= status.scan_last ? '0 : scan_count_reg + 1'b1;
            end
            if (cmd.load_out) begin
                if (cmd.out_kind == tpbd_pkg::KIND_CAL) begin
                    baseline_reg <= acc_reg[CW-1:0];
                end else begin
                    scan_max_reg <= '0;
                end
            end
        end
    end

    // accumulate kept samples, then replace the sum by its quotient in one step
    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (cmd.sum_add) begin
            acc_reg <= acc_reg + SUM_W'(cal_mem[sum_idx]);
        end else if (cmd.div_step) begin
            acc_reg <= SUM_W'(quotient);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_kind <= cmd.out_kind;
            if (cmd.out_kind == tpbd_pkg::KIND_CAL) begin
                out_touched  <= 1'b0;
                out_baseline <= acc_reg[CW-1:0];
            end else begin
                out_touched  <= hit;
                out_baseline <= baseline_reg;
            end
        end
    end

endmodule

@@ design/tpbd_ctrl.sv @@
// Controller: sequences accept, sort, sum, divide and result hand-off.
`include "assert_macros.svh"

module tpbd_ctrl #(
    parameter int CAL_SAMPLES   = 10,
    parameter int TRIM_EACH_END = 2,
    parameter int STEP_W        = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_mode,
    output logic               out_valid,
    input  logic               out_ready,
    input  tpbd_pkg::status_t  status,
    output tpbd_pkg::cmd_t     cmd,
    output logic [STEP_W-1:0]  step
);

    localparam int KEPT  = tpbd_pkg::kept_count(CAL_SAMPLES, TRIM_EACH_END);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              kind_reg;
    logic              out_valid_reg;
    logic              accept;
    logic              step_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign step      = step_reg;

    always_comb begin
        unique case (state_reg)
            ST_SORT: step_done = (step_reg == STEP_W'(CAL_SAMPLES - 1));
            ST_SUM:  step_done = (step_reg == STEP_W'(KEPT - 1));
            ST_DIV:  step_done = 1'b1;
            default: step_done = 1'b0;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.cal_write   = accept && (in_mode == tpbd_pkg::MODE_CAL);
        cmd.scan_update = accept && (in_mode == tpbd_pkg::MODE_SCAN);
        cmd.acc_clear   = cmd.cal_write && status.cal_last;
        cmd.sort_step   = (state_reg == ST_SORT);
        cmd.sum_add     = (state_reg == ST_SUM);
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.load_out    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        cmd.out_kind    = kind_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            kind_reg      <= tpbd_pkg::KIND_CAL;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (cmd.cal_write && status.cal_last) begin
                        kind_reg  <= tpbd_pkg::KIND_CAL;
                        state_reg <= ST_SORT;
                    end else if (cmd.scan_update && status.scan_last) begin
                        kind_reg  <= tpbd_pkg::KIND_SCAN;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SORT, ST_SUM, ST_DIV: begin
                    if (step_done) begin
                        step_reg <= '0;
                        unique case (state_reg)
                            ST_SORT: state_reg <= ST_SUM;
                            ST_SUM:  state_reg <= ST_DIV;
                            default: state_reg <= ST_EMIT;
                        endcase
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (cmd.load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TPBD_ASSERT_NEXT(a_cal_round_starts_sort, cmd.cal_write && status.cal_last, state_reg == ST_SORT && !in_ready)
    `TPBD_ASSERT_NEXT(a_div_ends_in_emit, state_reg == ST_DIV && step_done, state_reg == ST_EMIT)
    `TPBD_ASSERT_NEXT(a_emit_holds_on_stall, state_reg == ST_EMIT && out_valid_reg && !out_ready, state_reg == ST_EMIT && out_valid_reg)

endmodule

@@ sim/tpbd_report_checker.sv @@
// Report checker for the touch pad baseline/detect block: predicts each report and compares.
module tpbd_report_checker #(
    parameter int CAL_N   = 10,
    parameter int TRIM    = 2,
    parameter int GROUP_N = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_charge_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic        m_touched,
    input  logic [15:0] m_baseline_value,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // trim per end is clipped so at least one sample is averaged
    localparam int TRIM_USED = (2 * TRIM >= CAL_N) ? (CAL_N - 1) / 2 : TRIM;
    localparam int KEPT      = CAL_N - 2 * TRIM_USED;

    typedef struct packed {
        logic        kind;
        logic        touched;
        logic [15:0] baseline_value;
    } pad_report_t;

    pad_report_t reports_due[$];
    logic [15:0] cal_samples [CAL_N];
    int          cal_fill;
    int          group_fill;
    logic [15:0] group_peak;
    logic [15:0] cur_baseline;
    logic [15:0] threshold;
    int          errs = 0;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // insertion sort of the finished round, then mean of the middle samples
    function automatic logic [15:0] trimmed_mean_of_round();
        logic [15:0] ordered [CAL_N];
        logic [15:0] v;
        logic [31:0] total;
        int          j;
        for (int i = 0; i < CAL_N; i++) ordered[i] = cal_samples[i];
        for (int i = 1; i < CAL_N; i++) begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        total = '0;
        for (int i = TRIM_USED; i < TRIM_USED + KEPT; i++) total += ordered[i];
        return 16'(total / 32'(KEPT));
    endfunction

    always @(posedge aclk) begin : track
        pad_report_t due;
        logic [16:0] limit;
        if (!aresetn) begin
            reports_due.delete();
            cal_fill     = 0;
            group_fill   = 0;
            group_peak   = '0;
            cur_baseline = '0;
            threshold    = tpbd_pkg::THRESHOLD_RESET;
        end else begin
            if (cfg_wr_en) threshold = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("unexpected item: kind %0d touched %0d baseline_value %0d",
                           m_kind, m_touched, m_baseline_value);
                    errs++;
                end else begin
                    due = reports_due.pop_front();
                    if (m_kind !== due.kind) begin
                        $error("kind: expected %0d, got %0d", due.kind, m_kind);
                        errs++;
                    end
                    if (m_touched !== due.touched) begin
                        $error("touched: expected %0d, got %0d", due.touched, m_touched);
                        errs++;
                    end
                    if (m_baseline_value !== due.baseline_value) begin
                        $error("baseline_value: expected %0d, got %0d",
                               due.baseline_value, m_baseline_value);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_mode == tpbd_pkg::MODE_CAL) begin
                    cal_samples[cal_fill] = s_charge_count;
                    cal_fill++;
                    if (cal_fill == CAL_N) begin
                        cal_fill           = 0;
                        cur_baseline       = trimmed_mean_of_round();
                        due.kind           = tpbd_pkg::KIND_CAL;
                        due.touched        = 1'b0;
                        due.baseline_value = cur_baseline;
                        reports_due.push_back(due);
                    end
                end else begin
                    if (s_charge_count > group_peak) group_peak = s_charge_count;
                    group_fill++;
                    if (group_fill == GROUP_N) begin
                        // 17-bit sum, no wrap
                        limit              = {1'b0, cur_baseline} + {1'b0, threshold};
                        due.kind           = tpbd_pkg::KIND_SCAN;
                        due.touched        = {1'b0, group_peak} > limit;
                        due.baseline_value = cur_baseline;
                        reports_due.push_back(due);
                        group_fill = 0;
                        group_peak = '0;
                    end
                end
            end
        end
        mismatches  <= errs;
        outstanding <= reports_due.size();
    end

endmodule

@@ sim/tb_touch_pad_baseline_and_detect_core.sv @@
// Testbench top: drives calibration and scan items into the touch pad block and gives the verdict.
module tb_touch_pad_baseline_and_detect_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAL_N         = 10;
    localparam int TRIM          = 2;
    localparam int GROUP_N       = 3;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 73;
    localparam int SETTLE_CYCLES = 45;
    localparam int HOLD_CYCLES   = 300;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [15:0] cfg_wr_data    = '0;
    logic        s_valid        = 1'b0;
    logic        s_mode         = tpbd_pkg::MODE_CAL;
    logic [15:0] s_charge_count = '0;
    logic        m_ready        = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_kind;
    logic        m_touched;
    logic [15:0] m_baseline_value;
    int          mismatches;
    int          outstanding;

    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int hold_requests   = 0;
    int holds_seen      = 0;
    int hold_left       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    touch_pad_baseline_and_detect_core #(
        .CAL_SAMPLES  (CAL_N),
        .TRIM_EACH_END(TRIM),
        .SCAN_SAMPLES (GROUP_N)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_charge_count  (s_charge_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_touched       (m_touched),
        .m_baseline_value(m_baseline_value)
    );

    tpbd_report_checker #(
        .CAL_N  (CAL_N),
        .TRIM   (TRIM),
        .GROUP_N(GROUP_N)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_charge_count  (s_charge_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_touched       (m_touched),
        .m_baseline_value(m_baseline_value),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_seen != hold_requests) begin
            holds_seen <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !receiver_stalls || ($urandom_range(0, 99) >= 26);
        end
    end

    function automatic logic [15:0] clip16(input int v);
        return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic offer_sample(input logic mode, input logic [15:0] count);
        if (sender_gaps) begin
            while ($urandom_range(0, 99) < 26) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_charge_count <= count;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending, let every pending report drain, then give a long calibration time to finish
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int          level;
        int          value;
        logic        mode;
        logic [15:0] thr;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_threshold(16'd0);

        // calibration round of extremes with scan items mixed in; trimmed mean is 43690
        offer_sample(tpbd_pkg::MODE_CAL, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_CAL, 16'd0);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_CAL, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_CAL, 16'd0);
        offer_sample(tpbd_pkg::MODE_CAL, 16'd1);
        offer_sample(tpbd_pkg::MODE_CAL, 16'hFFFE);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd0);
        offer_sample(tpbd_pkg::MODE_CAL, 16'h8000);
        offer_sample(tpbd_pkg::MODE_CAL, 16'h7FFF);
        offer_sample(tpbd_pkg::MODE_CAL, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd0);
        offer_sample(tpbd_pkg::MODE_CAL, 16'hFFFF);
        // peak equal to the limit is no touch, one above is
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd43690);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd0);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd43690);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd43691);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd5);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd7);
        // peak must have been cleared after the last group
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd1);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd1);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'd1);
        wait_drained();
        set_threshold(16'hFFFF);
        // baseline + threshold exceeds 16 bits
        offer_sample(tpbd_pkg::MODE_SCAN, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'hFFFF);
        offer_sample(tpbd_pkg::MODE_SCAN, 16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            unique case (p % 5)
                0:       thr = 16'd0;
                1:       thr = 16'hFFFF;
                2:       thr = 16'($urandom_range(0, 400));
                3:       thr = tpbd_pkg::THRESHOLD_RESET;
                default: thr = 16'($urandom_range(0, 65535));
            endcase
            set_threshold(thr);
            level = (p == 4) ? 0 : (p == 6) ? 65535 : int'($urandom_range(0, 65535));
            sender_gaps     = (p != 3) && (p != 5);
            receiver_stalls = (p != 3);
            if (p == 5) hold_requests <= hold_requests + 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 7 && k == PHASE_ITEMS / 2) wait_drained();
                mode = ($urandom_range(0, 99) < ((p == 5) ? 10 : 35)) ?
                       tpbd_pkg::MODE_CAL : tpbd_pkg::MODE_SCAN;
                // mostly values near the baseline or near the touch limit
                if ($urandom_range(0, 99) < 20)
                    value = int'($urandom_range(0, 65535));
                else if (mode == tpbd_pkg::MODE_CAL)
                    value = level + int'($urandom_range(0, 128)) - 64;
                else
                    value = level + int'(thr) + int'($urandom_range(0, 160)) - 80;
                offer_sample(mode, clip16(value));
            end
        end

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // far beyond the slowest correct run
    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ touch_pad_baseline_and_detect_core.f @@
+incdir+design
design/tpbd_pkg.sv
design/tpbd_datapath.sv
design/tpbd_ctrl.sv
design/touch_pad_baseline_and_detect_core.sv
sim/tpbd_report_checker.sv
sim/tb_touch_pad_baseline_and_detect_core.sv
